// File: rtl/core/csb_pkg.sv
`default_nettype none

package csb_pkg;

    // Store geometry.
    localparam int CAPACITY_ITEMS = 32;
    localparam int WORD_WIDTH     = 32;
    localparam int IDX_W          = $clog2(CAPACITY_ITEMS);
    localparam int CNT_W          = IDX_W + 1;

    // Beat layout on both channels.
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Command codes; the two unused codes behave as a read.
    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/cursor_sequence_buffer_core.sv
// Ordered store of up to 32 words with a cursor, driven one command at a time.
// Input channel (i_s_*): one beat carries a command and a word for insert or
// attach. Output channel (o_m_*): exactly one result beat per command, with the
// word at the cursor, a flag for a current item, the item count and a flag
// for an insert or attach refused because the store is full.
// The block takes one command, works on it, offers the result and only then
// takes the next command. The storage is a single-port-write, single-port-read
// array, and insert, attach and remove move the items behind the cursor one at
// a time through it: each moved word is read and then written to its new place.
// Insert and attach move words up to open a gap and then write the new word;
// remove moves words down to close the gap. At most 31 words move for one
// command. Every command ends by reading the word at the cursor, waiting for
// the registered read data and then offering the result.
// A synchronous active-low reset empties the store and parks the cursor at
// the front; stale words in the array never reach the output.
// When the receiver holds i_m_tready low, the result beat is held stable and
// no new command is taken until it has been delivered.
`default_nettype none

module cursor_sequence_buffer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [2:0] command, [34:3] entry_value, [39:35] zero
    input  wire logic [csb_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [31:0] current_value, [32] has_current, [38:33] item_count, [39] rejected
    output logic [csb_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    localparam int IDX_W = csb_pkg::IDX_W;
    localparam int CNT_W = csb_pkg::CNT_W;
    localparam int WORD_W = csb_pkg::WORD_WIDTH;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(csb_pkg::CAPACITY_ITEMS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_DN_RD,
        ST_DN_WR,
        ST_LOOK,
        ST_LOOK_WAIT,
        ST_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cursor;
    logic [IDX_W-1:0]   r_j;
    logic [WORD_W-1:0]  r_word;
    logic               r_rej;
    logic [WORD_W-1:0]  r_out_value;
    logic               r_out_has;

    // Item storage with registered read data.
    logic [WORD_W-1:0]  r_mem [csb_pkg::CAPACITY_ITEMS];
    logic [WORD_W-1:0]  r_rd;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    // Incoming beat fields.
    csb_pkg::t_cmd      in_cmd;
    logic [WORD_W-1:0]  in_word;
    logic               in_take;
    logic               cur_valid;
    logic               full;
    logic [CNT_W-1:0]   attach_pos;

    assign in_cmd     = csb_pkg::t_cmd'(i_s_tdata[2:0]);
    assign in_word    = i_s_tdata[34:3];
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign cur_valid  = (r_cursor < r_count);
    assign full       = (r_count >= CAP);
    assign attach_pos = r_cursor + CNT_W'(1);

    // Memory port control, one access of each kind per cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_rd;
        mem_re    = 1'b0;
        mem_raddr = r_j;
        case (r_state)
            ST_UP_RD: begin
                mem_re = 1'b1;
            end
            ST_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_j + IDX_W'(1);
            end
            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cursor[IDX_W-1:0];
                mem_wdata = r_word;
            end
            ST_DN_RD: begin
                mem_re = 1'b1;
            end
            ST_DN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_j - IDX_W'(1);
            end
            ST_LOOK: begin
                mem_re    = 1'b1;
                mem_raddr = r_cursor[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // Command sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_word <= in_word;
                        r_rej  <= 1'b0;
                        r_state <= ST_LOOK;
                        case (in_cmd)
                            csb_pkg::CMD_START: begin
                                r_cursor <= '0;
                            end
                            csb_pkg::CMD_ADVANCE: begin
                                if (cur_valid) begin
                                    r_cursor <= r_cursor + CNT_W'(1);
                                end
                            end
                            csb_pkg::CMD_INSERT: begin
                                if (full) begin
                                    r_rej <= 1'b1;
                                end else begin
                                    // Without a current item the word goes to the front.
                                    if (!cur_valid) begin
                                        r_cursor <= '0;
                                    end
                                    r_j <= IDX_W'(r_count - CNT_W'(1));
                                    if (r_count > (cur_valid ? r_cursor : '0)) begin
                                        r_state <= ST_UP_RD;
                                    end else begin
                                        r_state <= ST_PUT;
                                    end
                                end
                            end
                            csb_pkg::CMD_ATTACH: begin
                                if (full) begin
                                    r_rej <= 1'b1;
                                end else if (cur_valid) begin
                                    r_cursor <= attach_pos;
                                    r_j      <= IDX_W'(r_count - CNT_W'(1));
                                    if (r_count > attach_pos) begin
                                        r_state <= ST_UP_RD;
                                    end else begin
                                        r_state <= ST_PUT;
                                    end
                                end else begin
                                    // Without a current item the word goes to the end.
                                    r_cursor <= r_count;
                                    r_state  <= ST_PUT;
                                end
                            end
                            csb_pkg::CMD_REMOVE: begin
                                if (cur_valid) begin
                                    if (attach_pos < r_count) begin
                                        r_j     <= attach_pos[IDX_W-1:0];
                                        r_state <= ST_DN_RD;
                                    end else begin
                                        r_count <= r_count - CNT_W'(1);
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_UP_RD: begin
                    r_state <= ST_UP_WR;
                end
                ST_UP_WR: begin
                    // The gap is open once the word at the cursor has moved up.
                    if (r_j == r_cursor[IDX_W-1:0]) begin
                        r_state <= ST_PUT;
                    end else begin
                        r_j     <= r_j - IDX_W'(1);
                        r_state <= ST_UP_RD;
                    end
                end
                ST_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= ST_LOOK;
                end
                ST_DN_RD: begin
                    r_state <= ST_DN_WR;
                end
                ST_DN_WR: begin
                    if (CNT_W'(r_j) == r_count - CNT_W'(1)) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= ST_LOOK;
                    end else begin
                        r_j     <= r_j + IDX_W'(1);
                        r_state <= ST_DN_RD;
                    end
                end
                ST_LOOK: begin
                    r_state <= ST_LOOK_WAIT;
                end
                ST_LOOK_WAIT: begin
                    r_out_has   <= cur_valid;
                    r_out_value <= cur_valid ? r_rd : '0;
                    r_state     <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = {r_rej, csb_pkg::COUNT_W'(r_count), r_out_has,
                         csb_pkg::VALUE_W'(r_out_value)};

`ifndef SYNTHESIS
    // The count never exceeds the capacity, and the cursor never passes the end.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CAP) && (r_cursor <= r_count))
        else $error("item count or cursor out of range");

    // A refused command is reported only against a full store.
    a_rej_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_rej) |-> (r_count == CAP))
        else $error("rejection reported with room in the store");

    // Input is never taken while a result is being offered.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    // After a delivered result the block is ready for the next command.
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |=> o_s_tready)
        else $error("block not ready after result delivery");
`endif

endmodule

`default_nettype wire
